// ----- sv/bwtil_pkg.sv -----
// shared constants and types for the inverse bwt last-to-first walk core
package bwtil_pkg;

    // default sizes
    localparam int MAX_LEN_DEF  = 64;
    localparam int ALPHABET_DEF = 128;

    // fixed field widths
    localparam int SYM_W     = 7;
    localparam int POS_OUT_W = 6;

    // terminator symbol '$'
    localparam logic [SYM_W-1:0] TERMINATOR = 7'd36;

    // error codes on the final result
    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NO_TERM  = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_WALK_CHK,
        S_WALK_ROW
    } t_state;

endpackage

// ----- sv/bwtil_ram.sv -----
// generic single-clock ram, one write port and one registered read port
module bwtil_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/bwtil_count_tbl.sv -----
// per-code count table: ram plus valid bits, an unwritten entry reads as zero
module bwtil_count_tbl #(
    parameter  int ALPHABET = 128,
    parameter  int CW       = 7,
    localparam int CAW      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  logic [CAW-1:0] i_rd_addr,
    input  logic           i_wr_en,
    input  logic [CAW-1:0] i_wr_addr,
    input  logic [CW-1:0]  i_wr_data,
    input  logic           i_clr,
    output logic [CW-1:0]  o_rd_data
);

    logic [ALPHABET-1:0] r_valid;
    logic                r_rd_vld;
    logic [CW-1:0]       ram_q;

    bwtil_ram #(
        .WIDTH (CW),
        .DEPTH (ALPHABET)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // valid bits, cleared all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // valid bit follows the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? ram_q : '0;

endmodule

// ----- sv/bwt_inverse_lf_walk_core.sv -----
// inverse burrows-wheeler transform core: load, prefix sum, last-to-first walk
//
//   channel   dir   handshake              payload
//   --------  ----  ---------------------  -------------------------------------------
//   command   in    start, busy            i_symbol, i_last_symbol
//   result    out   o_text_valid (strobe)  o_text_symbol, o_text_position,
//                                          o_end_of_text, o_error_code
//
// a symbol goes through a count table read, then count and store write-back.
// after the last symbol the prefix sum sweeps the count table, then the walk emits its
// results, each one after a store read and a count read.
// an overflowed string gives its single error result in the cycle after the last transfer.
// reset is synchronous; it empties the load state and clears all count valid bits.
// results are strobed for one cycle and cannot be held off.
module bwt_inverse_lf_walk_core #(
    parameter int MAX_LEN  = bwtil_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = bwtil_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bwtil_pkg::SYM_W-1:0]   i_symbol,
    input  logic                          i_last_symbol,
    output logic                          o_text_valid,
    output logic [bwtil_pkg::SYM_W-1:0]   o_text_symbol,
    output logic [bwtil_pkg::POS_OUT_W-1:0] o_text_position,
    output logic                          o_end_of_text,
    output logic [1:0]                    o_error_code
);

    import bwtil_pkg::*;

    localparam int CAW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int PW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int RW    = CW + 1;
    localparam int EW    = SYM_W + PW;
    localparam int RED_W = 15;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_len, n_len;
    logic                 r_ovf, n_ovf;
    logic [SYM_W-1:0]     r_sym, n_sym;
    logic                 r_last, n_last;
    logic [CAW:0]         r_c, n_c;
    logic [CW-1:0]        r_acc, n_acc;
    logic [SYM_W-1:0]     r_pend_sym, n_pend_sym;
    logic [PW-1:0]        r_pos, n_pos;
    logic [PW-1:0]        r_rank, n_rank;
    logic                 r_o_valid, n_o_valid;
    logic [SYM_W-1:0]     r_o_sym, n_o_sym;
    logic [POS_OUT_W-1:0] r_o_pos, n_o_pos;
    logic                 r_o_end, n_o_end;
    t_err                 r_o_err, n_o_err;

    logic [SYM_W-1:0]     sym_red;
    logic [RED_W-1:0]     red_v;

    logic                 cnt_rd_en, cnt_wr_en, cnt_clr;
    logic [CAW-1:0]       cnt_rd_addr, cnt_wr_addr;
    logic [CW-1:0]        cnt_wr_data, cnt_q;
    logic                 st_rd_en, st_wr_en;
    logic [PW-1:0]        st_rd_addr, st_wr_addr;
    logic [EW-1:0]        st_wr_data, st_q;
    logic [SYM_W-1:0]     st_sym;
    logic [PW-1:0]        st_rank;
    logic [RW-1:0]        row;

    // symbol reduced into the alphabet, restoring steps over the 7-bit code
    always_comb begin
        red_v = RED_W'(i_symbol);
        for (int k = SYM_W - 1; k >= 0; k--) begin
            if (red_v >= (RED_W'(ALPHABET) << k)) begin
                red_v = red_v - (RED_W'(ALPHABET) << k);
            end
        end
        sym_red = SYM_W'(red_v);
    end

    // per-code counts, later overwritten by the smaller-symbol totals
    bwtil_count_tbl #(
        .ALPHABET (ALPHABET),
        .CW       (CW)
    ) u_count_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (cnt_rd_en),
        .i_rd_addr (cnt_rd_addr),
        .i_wr_en   (cnt_wr_en),
        .i_wr_addr (cnt_wr_addr),
        .i_wr_data (cnt_wr_data),
        .i_clr     (cnt_clr),
        .o_rd_data (cnt_q)
    );

    // symbol and rank store
    bwtil_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_q)
    );

    assign st_sym  = st_q[EW-1:PW];
    assign st_rank = st_q[PW-1:0];

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_last     <= n_last;
        r_c        <= n_c;
        r_acc      <= n_acc;
        r_pend_sym <= n_pend_sym;
        r_pos      <= n_pos;
        r_rank     <= n_rank;
        r_o_sym    <= n_o_sym;
        r_o_pos    <= n_o_pos;
        r_o_end    <= n_o_end;
        r_o_err    <= n_o_err;
    end

    // next state, memory control and result
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_sym       = r_sym;
        n_last      = r_last;
        n_c         = r_c;
        n_acc       = r_acc;
        n_pend_sym  = r_pend_sym;
        n_pos       = r_pos;
        n_rank      = r_rank;
        n_o_valid   = 1'b0;
        n_o_sym     = r_o_sym;
        n_o_pos     = r_o_pos;
        n_o_end     = r_o_end;
        n_o_err     = r_o_err;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = '0;
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = '0;
        cnt_wr_data = '0;
        cnt_clr     = 1'b0;
        st_rd_en    = 1'b0;
        st_rd_addr  = '0;
        st_wr_en    = 1'b0;
        st_wr_addr  = '0;
        st_wr_data  = '0;
        row         = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_len < CW'(MAX_LEN)) begin
                        // fetch the running count of this code
                        cnt_rd_en   = 1'b1;
                        cnt_rd_addr = CAW'(sym_red);
                        n_sym       = sym_red;
                        n_last      = i_last_symbol;
                        n_state     = S_LOAD;
                    end else if (i_last_symbol) begin
                        // store full: single error result and reload
                        n_o_valid = 1'b1;
                        n_o_sym   = '0;
                        n_o_pos   = '0;
                        n_o_end   = 1'b1;
                        n_o_err   = ERR_OVERFLOW;
                        cnt_clr   = 1'b1;
                        n_len     = '0;
                        n_ovf     = 1'b0;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end

            S_LOAD: begin
                // bump the count, store symbol with its rank
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = CAW'(r_sym);
                cnt_wr_data = cnt_q + CW'(1);
                st_wr_en    = 1'b1;
                st_wr_addr  = r_len[PW-1:0];
                st_wr_data  = {r_sym, PW'(cnt_q)};
                n_len       = r_len + CW'(1);
                if (r_last) begin
                    n_c     = '0;
                    n_acc   = '0;
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_SUM: begin
                // read code c, write the running total of code c-1
                if (r_c < (CAW+1)'(ALPHABET)) begin
                    cnt_rd_en   = 1'b1;
                    cnt_rd_addr = CAW'(r_c);
                end
                if (r_c != '0) begin
                    cnt_wr_en   = 1'b1;
                    cnt_wr_addr = CAW'(r_c - (CAW+1)'(1));
                    cnt_wr_data = r_acc;
                    n_acc       = r_acc + cnt_q;
                end
                n_c = r_c + (CAW+1)'(1);
                if (r_c == (CAW+1)'(ALPHABET)) begin
                    // start the walk at row 0 with the terminator pending
                    st_rd_en   = 1'b1;
                    st_rd_addr = '0;
                    n_pend_sym = TERMINATOR;
                    n_pos      = PW'(r_len - CW'(1));
                    n_state    = S_WALK_CHK;
                end
            end

            S_WALK_CHK: begin
                // emit the pending symbol, its end flag now known
                n_o_valid = 1'b1;
                n_o_sym   = r_pend_sym;
                n_o_pos   = POS_OUT_W'(r_pos);
                n_o_end   = 1'b0;
                n_o_err   = ERR_OK;
                if (st_sym == TERMINATOR || r_pos == '0) begin
                    n_o_end = 1'b1;
                    n_o_err = (st_sym == TERMINATOR) ? ERR_OK : ERR_NO_TERM;
                    cnt_clr = 1'b1;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_pend_sym  = st_sym;
                    n_pos       = r_pos - PW'(1);
                    n_rank      = st_rank;
                    cnt_rd_en   = 1'b1;
                    cnt_rd_addr = CAW'(st_sym);
                    n_state     = S_WALK_ROW;
                end
            end

            S_WALK_ROW: begin
                // next row from smaller-symbol total plus rank
                row = RW'(cnt_q) + RW'(r_rank);
                if (row >= RW'(r_len)) begin
                    row = '0;
                end
                st_rd_en   = 1'b1;
                st_rd_addr = PW'(row);
                n_state    = S_WALK_CHK;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_text_valid    = r_o_valid;
    assign o_text_symbol   = r_o_sym;
    assign o_text_position = r_o_pos;
    assign o_end_of_text   = r_o_end;
    assign o_error_code    = r_o_err;

    // a nonzero error code only on the final result
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err != ERR_OK |-> r_o_end)
        else $error("error code on a non-final result");

    // overflow result carries a zero symbol and position
    a_ovf_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_err == ERR_OVERFLOW |-> r_o_sym == '0 && r_o_pos == '0)
        else $error("overflow result payload not zero");

    // walk results are never back to back
    a_walk_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_end |=> !r_o_valid)
        else $error("back-to-back walk results");

    // the final result comes with the load state emptied
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_end |-> r_len == '0 && r_state == S_IDLE && !r_ovf)
        else $error("load state not cleared at end of run");

    // loaded length never passes the store depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CW'(MAX_LEN))
        else $error("loaded length beyond store");

endmodule
